// ----- hdl/ahbt_pkg.sv -----
// shared types and constants of the access hazard barrier tracker
package ahbt_pkg;

    // word field widths
    localparam int TASK_W   = 16;
    localparam int RID_W    = 6;
    localparam int STAGE_W  = 32;
    localparam int TYPE_W   = 2;
    localparam int LAYOUT_W = 4;

    // largest resource count a resource id can address
    localparam int RES_MAX = 2 ** RID_W;
    // slot number: buffers first, images after them
    localparam int SLOT_W  = RID_W + 1;

    // defaults of the top level parameters
    localparam int DEF_RESOURCES  = 64;
    localparam int DEF_STAGE_BITS = 32;
    localparam int DEF_TASK_BITS  = 16;

    // depth of the queue between front and back
    localparam int Q_DEPTH = 2;

    // command codes
    localparam logic CMD_DECLARE = 1'b0;
    localparam logic CMD_ACCESS  = 1'b1;

    // access type bits
    localparam int TYPE_READ_BIT  = 0;
    localparam int TYPE_WRITE_BIT = 1;

    // classified access word, front to back
    typedef struct packed {
        logic                cmd;
        logic [TASK_W-1:0]   task_idx;
        logic                is_image;
        logic [RID_W-1:0]    resource_id;
        logic [STAGE_W-1:0]  new_stages;
        logic [TYPE_W-1:0]   new_type;
        logic [LAYOUT_W-1:0] acc_layout;
        logic                ign;
        logic [SLOT_W-1:0]   slot;
        logic [RID_W-1:0]    lidx;
    } t_acc_item;

    // barrier word as it leaves the block
    typedef struct packed {
        logic                barrier_valid;
        logic [TASK_W-1:0]   barrier_place;
        logic [STAGE_W-1:0]  awaited_stages;
        logic [TYPE_W-1:0]   awaited_type;
        logic [STAGE_W-1:0]  waiting_stages;
        logic [TYPE_W-1:0]   waiting_type;
        logic [LAYOUT_W-1:0] lay_before;
        logic [LAYOUT_W-1:0] lay_after;
        logic                img_barrier;
        logic [RID_W-1:0]    barrier_resource;
    } t_bar_word;

endpackage

// ----- hdl/ahbt_if.sv -----
// channel interfaces of the access hazard barrier tracker
interface ahbt_acc_if import ahbt_pkg::*; ;
    logic                valid;
    logic                ready;
    logic                cmd;
    logic [TASK_W-1:0]   task_idx;
    logic                is_image;
    logic [RID_W-1:0]    resource_id;
    logic [STAGE_W-1:0]  new_stages;
    logic [TYPE_W-1:0]   new_type;
    logic [LAYOUT_W-1:0] acc_layout;

    modport source (
        output valid, cmd, task_idx, is_image, resource_id, new_stages, new_type,
               acc_layout,
        input  ready
    );
    modport sink (
        input  valid, cmd, task_idx, is_image, resource_id, new_stages, new_type,
               acc_layout,
        output ready
    );
endinterface

interface ahbt_bar_if import ahbt_pkg::*; ;
    logic                valid;
    logic                ready;
    logic                barrier_valid;
    logic [TASK_W-1:0]   barrier_place;
    logic [STAGE_W-1:0]  awaited_stages;
    logic [TYPE_W-1:0]   awaited_type;
    logic [STAGE_W-1:0]  waiting_stages;
    logic [TYPE_W-1:0]   waiting_type;
    logic [LAYOUT_W-1:0] lay_before;
    logic [LAYOUT_W-1:0] lay_after;
    logic                img_barrier;
    logic [RID_W-1:0]    barrier_resource;

    modport source (
        output valid, barrier_valid, barrier_place, awaited_stages, awaited_type,
               waiting_stages, waiting_type, lay_before, lay_after,
               img_barrier, barrier_resource,
        input  ready
    );
    modport sink (
        input  valid, barrier_valid, barrier_place, awaited_stages, awaited_type,
               waiting_stages, waiting_type, lay_before, lay_after,
               img_barrier, barrier_resource,
        output ready
    );
endinterface

// ----- hdl/ahbt_front.sv -----
// front: accepts access words and classifies them into table slots
module ahbt_front import ahbt_pkg::*; #(
    parameter int RESOURCES = DEF_RESOURCES
) (
    ahbt_acc_if.sink  i_acc,
    output logic      o_push_valid,
    input  logic      i_push_ready,
    output t_acc_item o_push_data
);

    localparam int RES_EFF = (RESOURCES < RES_MAX) ? RESOURCES : RES_MAX;

    logic ign;

    // ids past the table are dropped without a state change
    assign ign = (int'(i_acc.resource_id) >= RES_EFF);

    assign o_push_valid = i_acc.valid;
    assign i_acc.ready  = i_push_ready;

    always_comb begin
        o_push_data.cmd         = i_acc.cmd;
        o_push_data.task_idx    = i_acc.task_idx;
        o_push_data.is_image    = i_acc.is_image;
        o_push_data.resource_id = i_acc.resource_id;
        o_push_data.new_stages  = i_acc.new_stages;
        o_push_data.new_type    = i_acc.new_type;
        o_push_data.acc_layout  = i_acc.acc_layout;
        o_push_data.ign         = ign;
        if (ign) begin
            o_push_data.slot = '0;
            o_push_data.lidx = '0;
        end else begin
            o_push_data.slot = i_acc.is_image
                ? SLOT_W'(i_acc.resource_id) + SLOT_W'(RES_EFF)
                : SLOT_W'(i_acc.resource_id);
            o_push_data.lidx = i_acc.resource_id;
        end
    end

endmodule

// ----- hdl/ahbt_queue.sv -----
// short fifo that decouples front and back
module ahbt_queue import ahbt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push_valid,
    output logic      o_push_ready,
    input  t_acc_item i_push_data,
    output logic      o_pop_valid,
    input  logic      i_pop_ready,
    output t_acc_item o_pop_data
);

    localparam int Q_AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_acc_item        r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr;
    logic [Q_AW-1:0]  r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/ahbt_back.sv -----
// back: access table read-modify-write, barrier decision and result register
module ahbt_back import ahbt_pkg::*; #(
    parameter int RESOURCES  = DEF_RESOURCES,
    parameter int STAGE_BITS = DEF_STAGE_BITS,
    parameter int TASK_BITS  = DEF_TASK_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    output logic       o_q_ready,
    input  t_acc_item  i_q_data,
    ahbt_bar_if.source o_bar
);

    localparam int RES_EFF = (RESOURCES < RES_MAX) ? RESOURCES : RES_MAX;
    localparam int SLOTS   = 2 * RES_EFF;
    localparam int SLOT_AW = $clog2(SLOTS);
    localparam int LAY_AW  = (RES_EFF > 1) ? $clog2(RES_EFF) : 1;
    localparam int ENT_W   = STAGE_BITS + TYPE_W + TASK_BITS;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                  r_state;
    logic                  n_state;
    t_acc_item             r_cur;
    logic [ENT_W-1:0]      r_ent_mem [SLOTS];
    logic [SLOTS-1:0]      r_ent_vld;
    logic [LAYOUT_W-1:0]   r_lay_mem [RES_EFF];
    logic [RES_EFF-1:0]    r_lay_vld;
    logic [ENT_W-1:0]      r_ent_rd;
    logic                  r_ent_rd_vld;
    logic [LAYOUT_W-1:0]   r_lay_rd;
    logic                  r_lay_rd_vld;
    logic [TASK_BITS-1:0]  r_bar_task;
    logic [TASK_BITS-1:0]  n_bar_task;
    t_bar_word             r_out;
    t_bar_word             n_out;
    logic                  r_out_valid;

    logic                  take;
    logic                  fire;
    logic [SLOT_AW-1:0]    rd_slot;
    logic [LAY_AW-1:0]     rd_lidx;
    logic [SLOT_AW-1:0]    wr_slot;
    logic [LAY_AW-1:0]     wr_lidx;
    logic [STAGE_BITS-1:0] old_stg;
    logic [TYPE_W-1:0]     old_type;
    logic [TASK_BITS-1:0]  old_task;
    logic [LAYOUT_W-1:0]   old_lay;
    logic [STAGE_BITS-1:0] cur_stg;
    logic [TASK_BITS-1:0]  cur_task;
    logic                  mem_b;
    logic                  exec_b;
    logic                  trans_b;
    logic                  bar_need;
    logic                  fresh;
    logic [TASK_BITS-1:0]  place;
    logic [ENT_W-1:0]      n_ent;
    logic                  ent_wr;
    logic                  lay_wr;

    // one word in flight: dequeue and table read, then decide and write back
    assign o_q_ready = (r_state == ST_IDLE);
    assign take      = (r_state == ST_IDLE) && i_q_valid;
    assign fire      = (r_state == ST_EXEC) && (!r_out_valid || o_bar.ready);

    assign rd_slot = i_q_data.slot[SLOT_AW-1:0];
    assign rd_lidx = i_q_data.lidx[LAY_AW-1:0];
    assign wr_slot = r_cur.slot[SLOT_AW-1:0];
    assign wr_lidx = r_cur.lidx[LAY_AW-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (take) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // entries never written read as zero
    always_comb begin
        old_stg  = r_ent_rd_vld ? r_ent_rd[ENT_W-1 -: STAGE_BITS] : '0;
        old_type = r_ent_rd_vld ? r_ent_rd[TASK_BITS +: TYPE_W] : '0;
        old_task = r_ent_rd_vld ? r_ent_rd[TASK_BITS-1:0] : '0;
        old_lay  = r_lay_rd_vld ? r_lay_rd : '0;
        cur_stg  = STAGE_BITS'(r_cur.new_stages);
        cur_task = TASK_BITS'(r_cur.task_idx);

        // write hazard: memory and execution barrier; write after read: execution only
        mem_b    = old_type[TYPE_WRITE_BIT];
        exec_b   = mem_b || (old_type[TYPE_READ_BIT] && r_cur.new_type[TYPE_WRITE_BIT]);
        trans_b  = r_cur.is_image && (r_cur.acc_layout != old_lay);
        bar_need = (r_cur.cmd == CMD_ACCESS) && !r_cur.ign && (mem_b || exec_b || trans_b);
        fresh    = (r_cur.cmd == CMD_DECLARE) || bar_need;

        // attach to the last barrier unless the resource was last used before it
        n_bar_task = r_bar_task;
        if (old_task >= r_bar_task) begin
            place = r_bar_task;
        end else begin
            place = cur_task;
            if (bar_need) begin
                n_bar_task = cur_task;
            end
        end

        if (fresh) begin
            n_ent = {cur_stg, r_cur.new_type, cur_task};
        end else begin
            n_ent = {old_stg | cur_stg, old_type | r_cur.new_type, cur_task};
        end
        ent_wr = fire && !r_cur.ign;
        lay_wr = ent_wr && r_cur.is_image && fresh;

        n_out = '0;
        if (bar_need) begin
            n_out.barrier_valid    = 1'b1;
            n_out.barrier_place    = TASK_W'(place);
            n_out.awaited_stages   = STAGE_W'(old_stg);
            n_out.awaited_type     = mem_b ? old_type : '0;
            n_out.waiting_stages   = STAGE_W'(cur_stg);
            n_out.waiting_type     = mem_b ? r_cur.new_type : '0;
            n_out.img_barrier      = r_cur.is_image;
            n_out.lay_before       = r_cur.is_image ? old_lay : '0;
            n_out.lay_after        = r_cur.is_image ? r_cur.acc_layout : '0;
            n_out.barrier_resource = r_cur.resource_id;
        end
    end

    // table storage
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_ent_rd <= r_ent_mem[rd_slot];
            r_lay_rd <= r_lay_mem[rd_lidx];
        end
        if (ent_wr) begin
            r_ent_mem[wr_slot] <= n_ent;
        end
        if (lay_wr) begin
            r_lay_mem[wr_lidx] <= r_cur.acc_layout;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cur        <= i_q_data;
            r_ent_rd_vld <= r_ent_vld[rd_slot];
            r_lay_rd_vld <= r_lay_vld[rd_lidx];
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ent_vld   <= '0;
            r_lay_vld   <= '0;
            r_bar_task  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ent_wr) begin
                r_ent_vld[wr_slot] <= 1'b1;
            end
            if (lay_wr) begin
                r_lay_vld[wr_lidx] <= 1'b1;
            end
            if (fire) begin
                r_bar_task  <= n_bar_task;
                r_out_valid <= 1'b1;
            end else if (o_bar.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_bar.valid            = r_out_valid;
    assign o_bar.barrier_valid    = r_out.barrier_valid;
    assign o_bar.barrier_place    = r_out.barrier_place;
    assign o_bar.awaited_stages   = r_out.awaited_stages;
    assign o_bar.awaited_type     = r_out.awaited_type;
    assign o_bar.waiting_stages   = r_out.waiting_stages;
    assign o_bar.waiting_type     = r_out.waiting_type;
    assign o_bar.lay_before       = r_out.lay_before;
    assign o_bar.lay_after        = r_out.lay_after;
    assign o_bar.img_barrier      = r_out.img_barrier;
    assign o_bar.barrier_resource = r_out.barrier_resource;

endmodule

// ----- hdl/access_hazard_barrier_tracker_unit.sv -----
// top level of the access hazard barrier tracker
//
// every word taken on i_acc gives exactly one word on o_bar, in order. a
// declare word (cmd 0) records a resource's initial stage mask, access type,
// task and, for images, layout, and returns an all-zero word. an access word
// (cmd 1) checks the stored last access of its resource: a stored write asks
// for a memory and execution barrier, a stored read followed by a write asks
// for an execution barrier only, and an image whose layout changes asks for a
// transition. a barrier is attached at the task of the last barrier when the
// resource was last touched at or after it, otherwise at the current task,
// which then becomes the barrier task. without a barrier the stored access
// accumulates the new one; with a barrier it is replaced. the stored task is
// always updated. resource ids at or above RESOURCES are dropped and return an
// all-zero word. the table starts cleared after reset with no sweep, since
// each entry carries a written bit. the back end takes one word at a time:
// it reads the table, then decides and writes back the same entry, and takes
// no new word in between. the input word and the table read are registered
// first, then the decision is registered into the result word offered on
// o_bar. a two-word queue between front and back lets the input keep
// flowing while a finished result waits on o_bar.
module access_hazard_barrier_tracker_unit import ahbt_pkg::*; #(
    parameter int RESOURCES  = DEF_RESOURCES,
    parameter int STAGE_BITS = DEF_STAGE_BITS,
    parameter int TASK_BITS  = DEF_TASK_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ahbt_acc_if.sink   i_acc,
    ahbt_bar_if.source o_bar
);

    // front to queue
    logic      push_valid;
    logic      push_ready;
    t_acc_item push_data;

    // queue to back
    logic      pop_valid;
    logic      pop_ready;
    t_acc_item pop_data;

    // classify: slot number and out-of-range drop
    ahbt_front #(
        .RESOURCES (RESOURCES)
    ) u_front (
        .i_acc        (i_acc),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    // decoupling queue
    ahbt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    // table update, barrier decision and output register
    ahbt_back #(
        .RESOURCES  (RESOURCES),
        .STAGE_BITS (STAGE_BITS),
        .TASK_BITS  (TASK_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (pop_valid),
        .o_q_ready (pop_ready),
        .i_q_data  (pop_data),
        .o_bar     (o_bar)
    );

endmodule
